FILE: rtl/stq_pkg.sv
// Shared codes, widths and cell control type for the sorted timer queue.
`default_nettype none

package stq_pkg;

    localparam int ID_W  = 16;
    localparam int EXP_W = 32;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_MODIFY = 2'd2;
    localparam logic [1:0] OP_TICK   = 2'd3;

    localparam logic [1:0] KIND_ACK     = 2'd0;
    localparam logic [1:0] KIND_EXPIRED = 2'd1;
    localparam logic [1:0] KIND_NONE    = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DUPLICATE = 2'd3;

    typedef struct packed {
        logic capture;   // register id match against the command
        logic insert;    // open a gap at the sorted spot and load the command
        logic remove;    // cells with shift set take their right neighbor
    } stq_cell_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/stq_cell.sv
// One slot of the timer chain: holds an entry, compares, shifts left or right.
`default_nettype none

module stq_cell
    import stq_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire stq_cell_ctl_t    ctl,
    input  wire logic [ID_W-1:0]  cmd_id,
    input  wire logic [EXP_W-1:0] cmd_expiry,
    input  wire logic             left_valid,
    input  wire logic [ID_W-1:0]  left_id,
    input  wire logic [EXP_W-1:0] left_expiry,
    input  wire logic             left_keep,
    input  wire logic             right_valid,
    input  wire logic [ID_W-1:0]  right_id,
    input  wire logic [EXP_W-1:0] right_expiry,
    input  wire logic             shift,
    output logic                  valid,
    output logic [ID_W-1:0]       id,
    output logic [EXP_W-1:0]      expiry,
    output logic                  keep,
    output logic                  match
);

    logic             valid_reg;
    logic             match_reg;
    logic [ID_W-1:0]  id_reg;
    logic [EXP_W-1:0] expiry_reg;

    logic take_right;
    logic take_left;
    logic take_new;

    // equal expiry stays in front of a newcomer
    assign keep       = valid_reg && (expiry_reg <= cmd_expiry);
    assign take_right = ctl.remove && shift;
    assign take_new   = ctl.insert && !keep && left_keep;
    assign take_left  = ctl.insert && !keep && !left_keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            if (take_right)
            begin
                valid_reg <= right_valid;
            end
            else if (take_new)
            begin
                valid_reg <= 1'b1;
            end
            else if (take_left)
            begin
                valid_reg <= left_valid;
            end
            if (ctl.capture)
            begin
                match_reg <= valid_reg && (id_reg == cmd_id);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take_right)
        begin
            id_reg     <= right_id;
            expiry_reg <= right_expiry;
        end
        else if (take_new)
        begin
            id_reg     <= cmd_id;
            expiry_reg <= cmd_expiry;
        end
        else if (take_left)
        begin
            id_reg     <= left_id;
            expiry_reg <= left_expiry;
        end
    end

    assign valid  = valid_reg;
    assign id     = id_reg;
    assign expiry = expiry_reg;
    assign match  = match_reg;

endmodule

`default_nettype wire

FILE: rtl/sorted_timer_queue.sv
// Top level of the sorted timer queue: command sequencer, cell chain, response register.
//
// Timers live in a chain of CAPACITY cells kept packed and in ascending expiry
// order, cell 0 being the head; an entry added with an expiry equal to others
// lands behind them. Add and delete pass through acceptance, an id compare in
// every cell, then one shift of the chain before the next command can be
// taken; modify shifts a second time, since the chain shifts once to drop the
// entry and once to put it back. A tick pops one expired entry per cycle while
// the response channel does not stall, because only the head cell is examined
// and popped; a tick with nothing due gives one word. Each command gives its
// words through a one-word response register, so a stalled response channel
// holds the sequencer. There is no clearing pass after reset.
`default_nettype none

module sorted_timer_queue
    import stq_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cmd_valid,
    output logic                  cmd_stall,
    input  wire logic [1:0]       op,
    input  wire logic [ID_W-1:0]  entry_id,
    input  wire logic [EXP_W-1:0] expire_time,
    input  wire logic [EXP_W-1:0] now_time,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output logic [1:0]            kind,
    output logic [1:0]            status,
    output logic [ID_W-1:0]       expired_id,
    output logic                  last
);

    localparam int LVL = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MATCH  = 3'd1;
    localparam logic [2:0] S_APPLY  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_TICK   = 3'd4;

    logic [2:0]       state_reg;
    logic [2:0]       state_next;
    logic [1:0]       op_reg;
    logic [ID_W-1:0]  id_reg;
    logic [EXP_W-1:0] exp_reg;
    logic [EXP_W-1:0] now_reg;

    logic             rsp_valid_reg;
    logic [1:0]       kind_reg;
    logic [1:0]       kind_next;
    logic [1:0]       status_reg;
    logic [1:0]       status_next;
    logic [ID_W-1:0]  expired_id_reg;
    logic [ID_W-1:0]  expired_id_next;
    logic             last_reg;
    logic             last_next;
    logic             load;
    logic             out_free;

    stq_cell_ctl_t    ctl;
    logic [CAPACITY-1:0] shift;
    logic [CAPACITY-1:0] cv;
    logic [CAPACITY-1:0] ck;
    logic [CAPACITY-1:0] cm;
    logic [ID_W-1:0]     cid  [CAPACITY];
    logic [EXP_W-1:0]    cexp [CAPACITY];

    logic [CAPACITY-1:0] pfx [LVL+1];
    logic                found;
    logic                full;
    logic                head_due;
    logic                next_due;

    // cell chain
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic             l_valid;
            logic [ID_W-1:0]  l_id;
            logic [EXP_W-1:0] l_exp;
            logic             l_keep;
            logic             r_valid;
            logic [ID_W-1:0]  r_id;
            logic [EXP_W-1:0] r_exp;

            if (gi == 0)
            begin : g_head
                assign l_valid = 1'b0;
                assign l_id    = '0;
                assign l_exp   = '0;
                assign l_keep  = 1'b1;
            end
            else
            begin : g_mid
                assign l_valid = cv[gi-1];
                assign l_id    = cid[gi-1];
                assign l_exp   = cexp[gi-1];
                assign l_keep  = ck[gi-1];
            end

            if (gi == CAPACITY-1)
            begin : g_tail
                assign r_valid = 1'b0;
                assign r_id    = '0;
                assign r_exp   = '0;
            end
            else
            begin : g_body
                assign r_valid = cv[gi+1];
                assign r_id    = cid[gi+1];
                assign r_exp   = cexp[gi+1];
            end

            stq_cell u_cell (
                .clk          (clk),
                .rst_n        (rst_n),
                .ctl          (ctl),
                .cmd_id       (id_reg),
                .cmd_expiry   (exp_reg),
                .left_valid   (l_valid),
                .left_id      (l_id),
                .left_expiry  (l_exp),
                .left_keep    (l_keep),
                .right_valid  (r_valid),
                .right_id     (r_id),
                .right_expiry (r_exp),
                .shift        (shift[gi]),
                .valid        (cv[gi]),
                .id           (cid[gi]),
                .expiry       (cexp[gi]),
                .keep         (ck[gi]),
                .match        (cm[gi])
            );
        end
    endgenerate

    // log-depth prefix OR: every cell at or behind the matching one shifts left
    assign pfx[0] = cm;
    generate
        for (gi = 0; gi < LVL; gi++)
        begin : g_pfx
            assign pfx[gi+1] = pfx[gi] | (pfx[gi] << (1 << gi));
        end
    endgenerate

    assign found    = |cm;
    assign full     = cv[CAPACITY-1];
    assign head_due = cv[0] && (cexp[0] <= now_reg);
    assign next_due = cv[1] && (cexp[1] <= now_reg);
    assign out_free = !rsp_valid_reg || !rsp_stall;

    always_comb
    begin
        state_next      = state_reg;
        ctl             = '0;
        shift           = '0;
        load            = 1'b0;
        kind_next       = KIND_ACK;
        status_next     = ST_OK;
        expired_id_next = '0;
        last_next       = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    state_next = (op == OP_TICK) ? S_TICK : S_MATCH;
                end
            end
            S_MATCH:
            begin
                ctl.capture = 1'b1;
                state_next  = S_APPLY;
            end
            S_APPLY:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = S_IDLE;
                    if (op_reg == OP_ADD)
                    begin
                        if (found)
                        begin
                            status_next = ST_DUPLICATE;
                        end
                        else if (full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            ctl.insert = 1'b1;
                        end
                    end
                    else if (!found)
                    begin
                        status_next = ST_NOT_FOUND;
                    end
                    else
                    begin
                        ctl.remove = 1'b1;
                        shift      = pfx[LVL];
                        if (op_reg == OP_MODIFY)
                        begin
                            // ack goes out once the entry is back in
                            load       = 1'b0;
                            state_next = S_INSERT;
                        end
                    end
                end
            end
            S_INSERT:
            begin
                if (out_free)
                begin
                    ctl.insert = 1'b1;
                    load       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_TICK:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (head_due)
                    begin
                        ctl.remove      = 1'b1;
                        shift           = '1;
                        kind_next       = KIND_EXPIRED;
                        expired_id_next = cid[0];
                        last_next       = !next_due;
                        if (!next_due)
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    else
                    begin
                        kind_next  = KIND_NONE;
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid)
        begin
            op_reg  <= op;
            id_reg  <= entry_id;
            exp_reg <= expire_time;
            now_reg <= now_time;
        end
        if (load)
        begin
            kind_reg       <= kind_next;
            status_reg     <= status_next;
            expired_id_reg <= expired_id_next;
            last_reg       <= last_next;
        end
    end

    assign cmd_stall  = (state_reg != S_IDLE);
    assign rsp_valid  = rsp_valid_reg;
    assign kind       = kind_reg;
    assign status     = status_reg;
    assign expired_id = expired_id_reg;
    assign last       = last_reg;

    // live entries stay packed toward the head
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((cv >> 1) & ~cv) == '0)
        else $error("timer chain has a hole");

    // ids are unique, so at most one cell can match
    a_unique: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(cm))
        else $error("more than one cell matched the id");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        cv[1] |-> (cexp[0] <= cexp[1]))
        else $error("head entries out of expiry order");

    a_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK && out_free && head_due)
        |=> ($countones(cv) + 1 == $past($countones(cv))))
        else $error("tick pop did not remove exactly one entry");

endmodule

`default_nettype wire

FILE: dv/sorted_timer_queue_tb.sv
// Self-checking testbench for the sorted timer queue: directed and random timer commands.
`default_nettype none

module sorted_timer_queue_tb;
    import stq_pkg::*;

    localparam int TIMER_SLOTS = 16;
    localparam int ID_POOL     = 24;
    localparam int IDLE_LIMIT  = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [1:0]       op;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] exp_t;
        logic [EXP_W-1:0] now_t;
    } timer_cmd_t;

    typedef struct packed {
        logic [1:0]      kind;
        logic [1:0]      status;
        logic [ID_W-1:0] xid;
        logic            last;
    } rsp_word_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cmd_valid = 1'b0;
    logic             cmd_stall;
    logic [1:0]       op = OP_TICK;
    logic [ID_W-1:0]  entry_id = '0;
    logic [EXP_W-1:0] expire_time = 32'd1;
    logic [EXP_W-1:0] now_time = '0;
    logic             rsp_valid;
    logic             rsp_stall = 1'b0;
    logic [1:0]       kind;
    logic [1:0]       status;
    logic [ID_W-1:0]  expired_id;
    logic             last;

    // shadow timer list, slot 0 is the head
    logic [EXP_W-1:0] tl_exp [TIMER_SLOTS];
    logic [ID_W-1:0]  tl_id [TIMER_SLOTS];
    int               tl_count = 0;

    timer_cmd_t pending_cmds [$];
    rsp_word_t  expected_words [$];
    int         cmds_pushed = 0;
    int         cmds_accepted = 0;
    int         words_seen = 0;
    int         err_count = 0;
    int         send_gap = 0;
    int         stall_left = 0;
    bit         hold_done = 1'b0;
    int         idle_cycles = 0;

    sorted_timer_queue #(.CAPACITY(TIMER_SLOTS)) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd_valid   (cmd_valid),
        .cmd_stall   (cmd_stall),
        .op          (op),
        .entry_id    (entry_id),
        .expire_time (expire_time),
        .now_time    (now_time),
        .rsp_valid   (rsp_valid),
        .rsp_stall   (rsp_stall),
        .kind        (kind),
        .status      (status),
        .expired_id  (expired_id),
        .last        (last)
    );

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("ERROR @%0t: %s", $time, what);
        err_count++;
    endtask

    function automatic int pick_gap(input int progress);
        int r;
        r = $urandom_range(0, 99);
        // every fourth stretch runs with no idling at all
        if ((progress / 16) % 4 == 2)
            return 0;
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void push_word(input logic [1:0] k, input logic [1:0] s,
                                      input logic [ID_W-1:0] xid, input logic l);
        rsp_word_t w;
        w.kind   = k;
        w.status = s;
        w.xid    = xid;
        w.last   = l;
        expected_words.push_back(w);
    endfunction

    function automatic void tl_remove(input int pos);
        int i;
        for (i = pos; i + 1 < tl_count; i++)
        begin
            tl_exp[i] = tl_exp[i + 1];
            tl_id[i]  = tl_id[i + 1];
        end
        tl_count--;
    endfunction

    // equal expiries: the new entry lands behind the older ones
    function automatic void tl_insert(input logic [ID_W-1:0] id, input logic [EXP_W-1:0] e);
        int pos;
        int i;
        pos = 0;
        while (pos < tl_count && tl_exp[pos] <= e)
            pos++;
        for (i = tl_count; i > pos; i--)
        begin
            tl_exp[i] = tl_exp[i - 1];
            tl_id[i]  = tl_id[i - 1];
        end
        tl_exp[pos] = e;
        tl_id[pos]  = id;
        tl_count++;
    endfunction

    function automatic void timer_list_apply(input timer_cmd_t c);
        int pos;
        int i;
        int popped;
        rsp_word_t w;
        pos = -1;
        popped = 0;
        for (i = 0; i < tl_count; i++)
            if (pos < 0 && tl_id[i] == c.id)
                pos = i;
        case (c.op)
            OP_ADD:
            begin
                if (pos >= 0)
                    push_word(KIND_ACK, ST_DUPLICATE, '0, 1'b1);
                else if (tl_count >= TIMER_SLOTS)
                    push_word(KIND_ACK, ST_FULL, '0, 1'b1);
                else
                begin
                    tl_insert(c.id, c.exp_t);
                    push_word(KIND_ACK, ST_OK, '0, 1'b1);
                end
            end
            OP_DELETE, OP_MODIFY:
            begin
                if (pos < 0)
                    push_word(KIND_ACK, ST_NOT_FOUND, '0, 1'b1);
                else
                begin
                    tl_remove(pos);
                    if (c.op == OP_MODIFY)
                        tl_insert(c.id, c.exp_t);
                    push_word(KIND_ACK, ST_OK, '0, 1'b1);
                end
            end
            default:
            begin
                while (tl_count > 0 && tl_exp[0] <= c.now_t)
                begin
                    push_word(KIND_EXPIRED, ST_OK, tl_id[0], 1'b0);
                    tl_remove(0);
                    popped++;
                end
                if (popped == 0)
                    push_word(KIND_NONE, ST_OK, '0, 1'b1);
                else
                begin
                    w = expected_words.pop_back();
                    w.last = 1'b1;
                    expected_words.push_back(w);
                end
            end
        endcase
    endfunction

    task automatic push_cmd(input logic [1:0] o, input logic [ID_W-1:0] id,
                            input logic [EXP_W-1:0] e, input logic [EXP_W-1:0] n);
        timer_cmd_t c;
        c.op    = o;
        c.id    = id;
        c.exp_t = e;
        c.now_t = n;
        pending_cmds.push_back(c);
        cmds_pushed++;
    endtask

    // command driver
    always @(posedge clk or negedge rst_n)
    begin : cmd_driver
        timer_cmd_t c;
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
        end
        else
        begin
            if (cmd_valid && !cmd_stall)
            begin
                c.op    = op;
                c.id    = entry_id;
                c.exp_t = expire_time;
                c.now_t = now_time;
                timer_list_apply(c);
                cmds_accepted++;
                send_gap = pick_gap(cmds_accepted);
            end
            if (!cmd_valid || !cmd_stall)
            begin
                if (send_gap > 0 || pending_cmds.size() == 0)
                begin
                    cmd_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
                else
                begin
                    c = pending_cmds.pop_front();
                    cmd_valid   <= 1'b1;
                    op          <= c.op;
                    entry_id    <= c.id;
                    expire_time <= c.exp_t;
                    now_time    <= c.now_t;
                end
            end
        end
    end

    // response stall: random stalls plus one long hold-off to back up the block
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_stall <= 1'b0;
        end
        else
        begin
            if (!hold_done && cmds_accepted >= 40)
            begin
                hold_done = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                rsp_stall <= 1'b1;
                stall_left--;
            end
            else
            begin
                rsp_stall <= 1'b0;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_gap(words_seen + 8);
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin : rsp_monitor
        rsp_word_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            words_seen++;
            if (expected_words.size() == 0)
                report_mismatch($sformatf("unexpected word kind=%0d status=%0d id=%h last=%b",
                                          kind, status, expired_id, last));
            else
            begin
                want = expected_words.pop_front();
                if (kind !== want.kind)
                    report_mismatch($sformatf("word %0d kind %0d, want %0d",
                                              words_seen, kind, want.kind));
                if (status !== want.status)
                    report_mismatch($sformatf("word %0d status %0d, want %0d",
                                              words_seen, status, want.status));
                if (expired_id !== want.xid)
                    report_mismatch($sformatf("word %0d expired_id %h, want %h",
                                              words_seen, expired_id, want.xid));
                if (last !== want.last)
                    report_mismatch($sformatf("word %0d last %b, want %b",
                                              words_seen, last, want.last));
            end
        end
    end

    // watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial
    begin
        logic [ID_W-1:0]  id_pool [ID_POOL];
        logic [EXP_W-1:0] base;
        logic [1:0]       o;
        logic [ID_W-1:0]  id;
        logic [EXP_W-1:0] e;
        logic [EXP_W-1:0] n;
        int               k;
        int               r;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty-queue cases, fill to capacity with ties, refusals, full drain
        push_cmd(OP_TICK, 16'($urandom_range(0, 65535)), 32'd7, 32'd0);
        push_cmd(OP_DELETE, 16'h0000, 32'd1, $urandom);
        push_cmd(OP_MODIFY, 16'hFFFF, 32'd5, $urandom);
        push_cmd(OP_ADD, 16'h0000, 32'hFFFF_FFFF, $urandom);
        push_cmd(OP_ADD, 16'hFFFF, 32'd1, $urandom);
        push_cmd(OP_ADD, 16'h5555, 32'd100, $urandom);
        push_cmd(OP_ADD, 16'hAAAA, 32'd100, $urandom);
        push_cmd(OP_ADD, 16'h0001, 32'd100, $urandom);
        push_cmd(OP_ADD, 16'h8000, 32'h8000_0000, $urandom);
        push_cmd(OP_ADD, 16'h0002, 32'h7FFF_FFFF, $urandom);
        for (k = 0; k < 9; k++)
            push_cmd(OP_ADD, 16'(k + 3), (k % 3 == 0) ? 32'd100 : 32'(k * 37 + 1), $urandom);
        push_cmd(OP_ADD, 16'h1234, 32'd20, $urandom);        // full
        push_cmd(OP_ADD, 16'h5555, 32'd20, $urandom);        // duplicate while full
        push_cmd(OP_MODIFY, 16'hFFFF, 32'd100, $urandom);    // re-enters behind equal expiries
        push_cmd(OP_TICK, 16'($urandom_range(0, 65535)), $urandom, 32'hFFFF_FFFF);
        push_cmd(OP_ADD, 16'h0007, 32'd40, $urandom);
        push_cmd(OP_DELETE, 16'h0007, $urandom, $urandom);
        push_cmd(OP_ADD, 16'h0009, 32'd40, $urandom);
        push_cmd(OP_TICK, 16'($urandom_range(0, 65535)), $urandom, 32'd39);   // nothing due

        // random: ids from a small pool so hits, ties and a full list are common
        for (k = 0; k < ID_POOL; k++)
            id_pool[k] = 16'($urandom_range(0, 65535));
        base = $urandom & 32'hEFFF_FFFF;
        for (k = 0; k < 73; k++)
        begin
            while (pending_cmds.size() > 3)
                @(posedge clk);
            r  = $urandom_range(0, 99);
            id = id_pool[$urandom_range(0, ID_POOL - 1)];
            e  = base + $urandom_range(1, 400);
            n  = base + $urandom_range(0, 400);
            if (r < 45)
                o = OP_ADD;
            else if (r < 60)
                o = OP_DELETE;
            else if (r < 75)
                o = OP_MODIFY;
            else
                o = OP_TICK;
            if (r >= 92)
            begin
                o  = 2'($urandom_range(0, 3));
                id = 16'($urandom_range(0, 65535));
                e  = $urandom;
                n  = $urandom;
            end
            if (e == 0)
                e = 32'd1;
            if (o == OP_TICK)
            begin
                if ($urandom_range(0, 9) == 0)
                    n = 32'hFFFF_FFFF;
                if ($urandom_range(0, 4) == 0)
                    base = base + $urandom_range(1, 300);
            end
            push_cmd(o, id, e, n);
        end

        while (cmds_accepted < cmds_pushed)
            @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
